// ----- rtl/sel_pkg.sv -----
// Shared constants, types and helper functions of the Sobel edge threshold block.
`default_nettype none

package sel_pkg;

    // Geometry and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int THR_W      = 11;
    localparam int SUM_W      = PIX_W + 2;
    localparam int MAG_W      = SUM_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Smallest frame dimension; one border pixel on each side
    localparam int MIN_DIM = 3;
    localparam int BORDER  = 1;

    // Register reset values
    localparam logic [WIDTH_W-1:0] RST_FRAME_WIDTH    = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]   RST_FRAME_HEIGHT   = ROW_W'(480);
    localparam logic [THR_W-1:0]   RST_EDGE_THRESHOLD = THR_W'(128);

    // Result codes and magnitude bound
    localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;
    localparam logic [MAG_W-1:0] MAG_MAX  = MAG_W'(2040);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } t_cfg_reg;

    // Position and flags that travel with a pixel down the pipe
    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_tag;

    // Stage 1 payload: pixel, line store address, emit flag, output tag
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] addr;
        logic             emit;
        t_tag             tag;
    } t_s1;

    // 1,2,1 weighted sum of three pixels
    function automatic logic [SUM_W-1:0] kernel_sum(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        kernel_sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // Absolute difference of two sums
    function automatic logic [SUM_W-1:0] abs_diff(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sel_line_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module sel_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [DATA_W-1:0]         i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [DATA_W-1:0]         o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/sobel_edge_threshold.sv -----
// An interior pixel's result passes stage 1, stage 2, stage 3 and the output register to o_out_valid.
// Throughput: one pixel per cycle while the pipeline advances; the line store RAM is read and written once per pixel.
// The pipeline advances as one whole while the output register is empty or being taken.
// Reset (synchronous, active low) clears position counters, window, valids and registers.
// Line store contents are not cleared by reset.
`default_nettype none

module sobel_edge_threshold
    import sel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_frame_start,
    // edge result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_edge_value,
    output logic [MAG_W-1:0]      o_magnitude,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [COL_W-1:0]      o_out_col,
    output logic                  o_last_of_frame
);

    // Configuration registers
    logic [WIDTH_W-1:0] r_frame_width;
    logic [ROW_W-1:0]   r_frame_height;
    logic [THR_W-1:0]   r_edge_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= RST_FRAME_WIDTH;
            r_frame_height   <= RST_FRAME_HEIGHT;
            r_edge_threshold <= RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[ROW_W-1:0];
                REG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry, clamped to the supported range
    logic [WIDTH_W-1:0] w_eff, w_last;
    logic [ROW_W-1:0]   h_eff, h_last;

    always_comb begin
        if (r_frame_width < WIDTH_W'(MIN_DIM)) begin
            w_eff = WIDTH_W'(MIN_DIM);
        end else if (r_frame_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < ROW_W'(MIN_DIM)) begin
            h_eff = ROW_W'(MIN_DIM);
        end else begin
            h_eff = r_frame_height;
        end
        w_last = w_eff - WIDTH_W'(1);
        h_last = h_eff - ROW_W'(1);
    end

    // Pipeline advance: whole pipe moves when the output register can take data
    logic r_out_valid;
    logic adv;
    logic in_accept;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign in_accept  = i_in_valid && adv;

    // Stage 0: position of the incoming pixel and counter update
    logic [COL_W-1:0] r_col, n_col, col0;
    logic [ROW_W-1:0] r_row, n_row, row0;
    logic             emit0, last0;

    always_comb begin
        col0  = i_frame_start ? '0 : r_col;
        row0  = i_frame_start ? '0 : r_row;
        emit0 = (col0 > COL_W'(BORDER)) && (row0 > ROW_W'(BORDER))
                && ({1'b0, col0} < w_eff) && (row0 < h_eff);
        last0 = ({1'b0, col0} == w_last) && (row0 == h_last);
        if ({1'b0, col0} >= w_last) begin
            n_col = '0;
            n_row = (row0 >= h_last) ? '0 : row0 + ROW_W'(1);
        end else begin
            n_col = col0 + COL_W'(1);
            n_row = row0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 registers
    logic r_s1_valid;
    t_s1  r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1.pixel    <= i_pixel;
            r_s1.addr     <= col0;
            r_s1.emit     <= emit0;
            r_s1.tag.last <= last0;
            r_s1.tag.row  <= row0 - ROW_W'(BORDER);
            r_s1.tag.col  <= col0 - COL_W'(BORDER);
        end
    end

    // Line store RAM: word = {upper line, middle line}
    logic                   s1_write;
    logic [2*PIX_W-1:0]     ram_rdata;
    logic [2*PIX_W-1:0]     ram_wdata;
    logic [2*PIX_W-1:0]     rd_word;
    logic                   r_fwd;
    logic [2*PIX_W-1:0]     r_fwd_data;
    logic [PIX_W-1:0]       px_top, px_mid, px_bot;

    assign s1_write = adv && r_s1_valid;

    sel_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2*PIX_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_write),
        .i_waddr (r_s1.addr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (col0),
        .o_rdata (ram_rdata)
    );

    // Forward the write-back when the next pixel reads the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (adv) begin
            r_fwd <= s1_write && in_accept && (col0 == r_s1.addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_data <= ram_wdata;
        end
    end

    assign rd_word   = r_fwd ? r_fwd_data : ram_rdata;
    assign px_top    = rd_word[2*PIX_W-1:PIX_W];
    assign px_mid    = rd_word[PIX_W-1:0];
    assign px_bot    = r_s1.pixel;
    assign ram_wdata = {px_mid, r_s1.pixel};

    // Window of the two previous columns: [0..2] oldest top/mid/bot, [3..5] newer
    logic [PIX_W-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_write) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= px_top;
            r_win[4] <= px_mid;
            r_win[5] <= px_bot;
        end
    end

    // Stage 2: weighted column and row sums
    logic             r_s2_valid;
    t_tag             r_s2_tag;
    logic [SUM_W-1:0] r_left, r_right, r_upper, r_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_tag <= r_s1.tag;
            r_left   <= kernel_sum(r_win[0], r_win[1], r_win[2]);
            r_right  <= kernel_sum(px_top, px_mid, px_bot);
            r_upper  <= kernel_sum(r_win[0], r_win[3], px_top);
            r_lower  <= kernel_sum(r_win[2], r_win[5], px_bot);
        end
    end

    // Stage 3: gradient magnitudes per direction
    logic             r_s3_valid;
    t_tag             r_s3_tag;
    logic [SUM_W-1:0] r_gx_abs, r_gy_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_tag <= r_s2_tag;
            r_gx_abs <= abs_diff(r_right, r_left);
            r_gy_abs <= abs_diff(r_upper, r_lower);
        end
    end

    // Output register: total magnitude and threshold compare
    logic [MAG_W-1:0] mag;
    logic [PIX_W-1:0] r_edge_value;
    logic [MAG_W-1:0] r_magnitude;
    t_tag             r_out_tag;

    assign mag = {1'b0, r_gx_abs} + {1'b0, r_gy_abs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s3_valid) begin
            r_edge_value <= (mag > r_edge_threshold) ? EDGE_ON : EDGE_OFF;
            r_magnitude  <= mag;
            r_out_tag    <= r_s3_tag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_edge_value    = r_edge_value;
    assign o_magnitude     = r_magnitude;
    assign o_out_row       = r_out_tag.row;
    assign o_out_col       = r_out_tag.col;
    assign o_last_of_frame = r_out_tag.last;

endmodule

`default_nettype wire

// ----- rtl/sel_checker.sv -----
// Port-level checker for the Sobel edge threshold block, with its bind.
`default_nettype none

module sel_checker
    import sel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  o_in_ready,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  logic [PIX_W-1:0]      o_edge_value,
    input  logic [MAG_W-1:0]      o_magnitude,
    input  logic [ROW_W-1:0]      o_out_row,
    input  logic [COL_W-1:0]      o_out_col,
    input  logic                  o_last_of_frame
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_edge_value)
        && $stable(o_magnitude) && $stable(o_out_row) && $stable(o_out_col)
        && $stable(o_last_of_frame))
        else $error("result changed while stalled");

    // Input is never blocked while the output register is empty
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Result code is binary
    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_edge_value == EDGE_ON) || (o_edge_value == EDGE_OFF))
        else $error("bad edge value");

    // Magnitude stays within the kernel's range
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_magnitude <= MAG_MAX)
        else $error("magnitude out of range");

    // Results come only from interior positions
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_row != '0) && (o_out_col != '0))
        else $error("result on a border position");

endmodule

bind sobel_edge_threshold sel_checker u_sel_checker (.*);

`default_nettype wire

// ----- test/sobel_edge_threshold_chk.sv -----
// Result checker for the Sobel edge threshold block: watches both channels, predicts, compares.
module sobel_edge_threshold_chk
    import sel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // register writes as seen by the block
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_frame_start,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [PIX_W-1:0]      i_edge_value,
    input  logic [MAG_W-1:0]      i_magnitude,
    input  logic [ROW_W-1:0]      i_out_row,
    input  logic [COL_W-1:0]      i_out_col,
    input  logic                  i_last_of_frame,
    output int                    o_mismatch_count,
    output int                    o_results_due
);

    typedef struct {
        logic [PIX_W-1:0] edge_value;
        logic [MAG_W-1:0] magnitude;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_edge_result;

    // Shadow of the block's registers and pixel history
    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [PIX_W-1:0]   upper_line  [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]   left_col    [3];   // two columns back: top, mid, bottom
    logic [PIX_W-1:0]   center_col  [3];   // one column back
    int unsigned        col_pos;
    int unsigned        row_pos;

    t_edge_result edge_results_due [$];
    t_edge_result due;
    int           mismatches = 0;

    assign o_mismatch_count = mismatches;

    // Advance the 3x3 window by one pixel; queue the edge result it yields, if any
    task automatic sobel_window_step(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned  w, h, col, row, top, mid, bot;
        int unsigned  gx_left, gx_right, gy_upper, gy_lower, mag;
        t_edge_result res;
        w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        top = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = PIX_W'(mid);
        middle_line[col] = px;
        bot = px;
        // interior pixels only
        if (col >= 2 && row >= 2 && col < w && row < h) begin
            gx_left  = left_col[0] + 2 * left_col[1] + left_col[2];
            gx_right = top + 2 * mid + bot;
            gy_upper = left_col[0] + 2 * center_col[0] + top;
            gy_lower = left_col[2] + 2 * center_col[2] + bot;
            mag = ((gx_right >= gx_left) ? gx_right - gx_left : gx_left - gx_right)
                + ((gy_upper >= gy_lower) ? gy_upper - gy_lower : gy_lower - gy_upper);
            res.edge_value = (mag > thr_reg) ? EDGE_ON : EDGE_OFF;
            res.magnitude  = MAG_W'(mag);
            res.row        = ROW_W'(row - 1);
            res.col        = COL_W'(col - 1);
            res.last       = (col == w - 1 && row == h - 1);
            edge_results_due.push_back(res);
        end
        // shift the window one column left
        for (int k = 0; k < 3; k++) begin
            left_col[k] = center_col[k];
        end
        center_col[0] = PIX_W'(top);
        center_col[1] = PIX_W'(mid);
        center_col[2] = PIX_W'(bot);
        // raster position
        if (col >= w - 1) begin
            col_pos = 0;
            row_pos = (row >= h - 1) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Register writes, result transactions, then pixel transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            thr_reg    = RST_EDGE_THRESHOLD;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                left_col[k]   = '0;
                center_col[k] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            edge_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:    width_reg  = i_cfg_data[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT:   height_reg = i_cfg_data[ROW_W-1:0];
                    REG_EDGE_THRESHOLD: thr_reg    = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (edge_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual magnitude %0d",
                             $time, i_magnitude);
                end else begin
                    due = edge_results_due.pop_front();
                    check_field("edge_value", 32'(due.edge_value), 32'(i_edge_value));
                    check_field("magnitude", 32'(due.magnitude), 32'(i_magnitude));
                    check_field("out_row", 32'(due.row), 32'(i_out_row));
                    check_field("out_col", 32'(due.col), 32'(i_out_col));
                    check_field("last_of_frame", 32'(due.last), 32'(i_last_of_frame));
                end
            end
            if (i_in_valid && i_in_ready) begin
                sobel_window_step(i_pixel, i_frame_start);
            end
        end
        o_results_due <= edge_results_due.size();
    end

endmodule

// ----- test/sobel_edge_threshold_tb.sv -----
// Testbench top: drives pixel frames and register writes into the Sobel edge block.
module sobel_edge_threshold_tb;
    import sel_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_PIXELS = 330;
    localparam int WIDE_PIXELS  = 300;

    typedef enum {PIX_PEAK, PIX_FLAT, PIX_NOISE, PIX_BINARY, PIX_SMOOTH} t_pix_mode;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel       = '0;
    logic                  frame_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [PIX_W-1:0]      edge_value;
    logic [MAG_W-1:0]      magnitude;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  last_of_frame;

    int mismatch_count;
    int results_due;
    int cycle_count   = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 73;
    int pixels_sent   = 0;
    int cur_w, cur_h, new_w, new_h, frame_px, phase, phase_goal, pick;
    logic need_fs;
    logic fs_first;
    t_pix_mode mode;

    sobel_edge_threshold u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_pixel         (pixel),
        .i_frame_start   (frame_start),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_edge_value    (edge_value),
        .o_magnitude     (magnitude),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_last_of_frame (last_of_frame)
    );

    sobel_edge_threshold_chk u_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_pixel          (pixel),
        .i_frame_start    (frame_start),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_edge_value     (edge_value),
        .i_magnitude      (magnitude),
        .i_out_row        (out_row),
        .i_out_col        (out_col),
        .i_last_of_frame  (last_of_frame),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off pixels until every predicted result is out, then let the pipe settle
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0) @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One pixel transaction per loop pass, with random sender gaps
    task automatic send_pixels(input int n_px, input int fw, input t_pix_mode pmode,
                               input logic restart, input logic noisy);
        int               col, row, base;
        logic [PIX_W-1:0] px;
        logic             fs;
        base = $urandom_range(0, 240);
        for (int i = 0; i < n_px; i++) begin
            col = i % fw;
            row = i / fw;
            case (pmode)
                PIX_PEAK:   px = ((row == 0 && col >= 1) || (row == 1 && col == 2)) ?
                                 EDGE_ON : EDGE_OFF;
                PIX_FLAT:   px = EDGE_ON;
                PIX_BINARY: px = $urandom_range(1) ? EDGE_ON : EDGE_OFF;
                PIX_SMOOTH: px = PIX_W'(base + $urandom_range(0, 15));
                default:    px = PIX_W'($urandom_range(0, 255));
            endcase
            fs = (i == 0) ? restart : (noisy && $urandom_range(199) == 0);
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            pixel       <= px;
            frame_start <= fs;
            @(negedge clk);
            while (!in_ready) @(negedge clk);
            @(posedge clk);
            pixels_sent++;
        end
    endtask

    // New random geometry and threshold; out-of-range sizes and spare data bits included
    task automatic reconfigure();
        int w_val, h_val, t_val;
        wait_drained(DRAIN_CYCLES);
        w_val = ($urandom_range(99) < 10) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        h_val = ($urandom_range(99) < 10) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        case ($urandom_range(4))
            0:       t_val = 0;
            1:       t_val = int'(MAG_MAX);
            2:       t_val = 2047;
            3:       t_val = $urandom_range(0, 2047);
            default: t_val = $urandom_range(0, 700);
        endcase
        write_reg(REG_FRAME_WIDTH, {1'($urandom_range(1)), WIDTH_W'(w_val)});
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
        write_reg(REG_EDGE_THRESHOLD, {1'($urandom_range(1)), THR_W'(t_val)});
        cur_w   = (w_val < MIN_DIM) ? MIN_DIM : w_val;
        cur_h   = (h_val < MIN_DIM) ? MIN_DIM : h_val;
        need_fs = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: smallest frame, peak magnitude just over and at the threshold,
        // wrap into the next frame without a frame start, flat frame at threshold zero
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'(1529));
        send_pixels(9, 3, PIX_PEAK, 1'b1, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'(1530));
        send_pixels(9, 3, PIX_PEAK, 1'b0, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(REG_EDGE_THRESHOLD, '0);
        send_pixels(9, 3, PIX_FLAT, 1'b1, 1'b0);
        cur_w   = 3;
        cur_h   = 3;
        need_fs = 1'b0;

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // part of a line at the clamped full width
            if (phase == 2) begin
                wait_drained(DRAIN_CYCLES);
                write_reg(REG_FRAME_WIDTH, {CFG_DATA_W{1'b1}});
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
                write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 1200)));
                send_pixels(WIDE_PIXELS, MAX_WIDTH, PIX_NOISE, 1'b1, 1'b0);
                reconfigure();
            end
            phase_goal = pixels_sent + PHASE_PIXELS;
            while (pixels_sent < phase_goal) begin
                if ($urandom_range(99) < 30) begin
                    reconfigure();
                end
                frame_px = cur_w * cur_h;
                fs_first = need_fs || ($urandom_range(99) < 60);
                need_fs  = 1'b0;
                case ($urandom_range(2))
                    0:       mode = PIX_NOISE;
                    1:       mode = PIX_BINARY;
                    default: mode = PIX_SMOOTH;
                endcase
                pick = $urandom_range(99);
                if (pick < 12) begin
                    // frame cut short
                    send_pixels($urandom_range(1, frame_px - 1), cur_w, mode, fs_first, 1'b1);
                end else if (pick < 22) begin
                    // height changes or width shrinks in the middle of a frame
                    send_pixels($urandom_range(1, frame_px - 1), cur_w, mode, fs_first, 1'b0);
                    wait_drained(DRAIN_CYCLES);
                    new_w = $urandom_range(0, cur_w);
                    new_h = $urandom_range(0, 8);
                    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(new_w));
                    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(new_h));
                    cur_w = (new_w < MIN_DIM) ? MIN_DIM : new_w;
                    cur_h = (new_h < MIN_DIM) ? MIN_DIM : new_h;
                    send_pixels(cur_w * cur_h, cur_w, mode, 1'b0, 1'b0);
                    need_fs = 1'b1;
                end else begin
                    send_pixels(frame_px, cur_w, mode, fs_first, 1'b1);
                end
            end
        end

        wait_drained(4 * DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
